[src/balt_pkg.sv]
package balt_pkg;

    localparam int CoordBits = 32;
    localparam int MulW      = 34;
    localparam int ProdW     = 2 * MulW;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_BUILD   = 2'd1,
        CMD_READ    = 2'd2,
        CMD_ADVANCE = 2'd3
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CMUL,
        ST_CMULW,
        ST_AMUL,
        ST_AACC,
        ST_RMUL,
        ST_QMUL,
        ST_QSUB,
        ST_DIV,
        ST_DIVW,
        ST_SMUL,
        ST_SACC,
        ST_SQRT,
        ST_BWR,
        ST_RD,
        ST_RDW,
        ST_ADV,
        ST_ADVW,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [31:0] cum;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } t_row;

endpackage

[src/balt_ram.sv]
module balt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 151
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/bezier_arc_length_table_core.sv]
// Cubic Bezier arc-length table. Load transactions store control points P0..P3. A
// build transaction samples the curve at SEGMENTS+1 points through one shared 34x34
// multiplier, which also divides each coordinate by a reciprocal multiplication
// followed by up to three correction steps, and a one-bit-per-cycle square root.
// An advance walks the table entry by entry through the single read port of the
// sample memory. One transaction is in work at a time; a finished result waits in
// the output register while the next input transaction is taken. Reading the table
// before the first build returns undefined data.
module bezier_arc_length_table_core #(
    parameter int SEGMENTS = 150
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // point_slot[1:0], in_x[33:2], in_y[65:34], in_z[97:66],
    // sample_index[105:98], travel[136:106], zero fill up to bit 143
    input  logic [143:0] i_s_axis_tdata,
    // command[1:0]
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_distance[127:96], out_index[135:128]
    output logic [135:0] o_m_axis_tdata,
    // past_end[0]
    output logic [0:0]   o_m_axis_tuser
);
    import balt_pkg::*;

    localparam int AW = $clog2(SEGMENTS + 1);
    localparam int IW = (AW > 8) ? AW : 8;
    localparam longint unsigned Den = 64'(SEGMENTS) * 64'(SEGMENTS) * 64'(SEGMENTS);
    localparam int DenW = $clog2(Den + 1);
    localparam longint unsigned Half = Den / 2;
    localparam int NumShift = DenW - 1;
    localparam longint unsigned Recip = (64'(1) << (DenW + 31)) / Den;
    localparam logic [DenW+1:0] RemDen = (DenW + 2)'(Den);
    localparam logic [AW-1:0] LastK = AW'(SEGMENTS);
    localparam logic [ProdW-1:0] MaxPos = ProdW'((64'(1) << (CoordBits - 1)) - 1);

    t_state r_state, n_state;

    logic signed [31:0] r_ctrl_x [4];
    logic signed [31:0] r_ctrl_y [4];
    logic signed [31:0] r_ctrl_z [4];
    logic signed [MulW-1:0] r_coef [4];
    logic signed [MulW-1:0] r_aa, r_bb;
    logic signed [31:0] r_new [3];
    logic signed [31:0] r_prev [3];
    logic [31:0] r_prev_cum;
    logic [AW-1:0] r_k;
    logic [2:0] r_op;
    logic [1:0] r_term, r_coord;
    logic signed [ProdW-1:0] r_acc, r_prod;
    logic [ProdW-1:0] r_dq;
    logic [ProdW-1:0] r_num;
    logic [DenW+1:0] r_rem;
    logic r_neg;
    logic [65:0] r_sq;
    logic r_sat;
    logic [63:0] r_v, r_res, r_bit;
    logic r_adv;
    logic [30:0] r_travel;
    logic [31:0] r_base;
    t_row r_row, r_result, r_out;
    logic [7:0] r_result_idx, r_out_idx;
    logic r_result_pe, r_out_pe, r_out_valid;

    logic mem_we;
    t_row mem_wdata, mem_rdata;
    logic signed [MulW-1:0] mul_a, mul_b;
    logic [AW-1:0] a_val;
    logic signed [MulW-1:0] a_ext, b_ext;
    logic signed [31:0] pt;
    logic signed [32:0] dif;
    logic [32:0] adif;
    logic signed [ProdW-1:0] n_acc, acc_abs;
    logic [MulW-1:0] num_top, q_hat;
    logic [64:0] sq_t;
    logic [65:0] n_sq;
    logic [32:0] cum_sum;
    logic [31:0] cum_new, adv_diff;
    logic [MulW-1:0] tri_prod;
    logic signed [31:0] div_val;
    logic [IW-1:0] idx_in;
    logic [AW-1:0] idx_cl;
    logic accept;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign a_val = LastK - r_k;
    assign a_ext = signed'(MulW'(a_val));
    assign b_ext = signed'(MulW'(r_k));
    assign dif = 33'(r_new[r_coord]) - 33'(r_prev[r_coord]);
    assign adif = dif[32] ? unsigned'(-dif) : unsigned'(dif);
    assign n_acc = r_acc + r_prod;
    assign acc_abs = n_acc[ProdW-1] ? -n_acc : n_acc;
    assign num_top = MulW'(r_num >> NumShift);
    assign q_hat = r_prod[32 +: MulW];
    assign sq_t = {1'b0, r_res} + {1'b0, r_bit};
    assign n_sq = r_sq + 66'(unsigned'(r_prod[63:0]));
    assign cum_sum = {1'b0, r_prev_cum} + {1'b0, (r_sat ? 32'hFFFF_FFFF : r_res[31:0])};
    assign cum_new = (r_k == '0) ? 32'd0 : (cum_sum[32] ? 32'hFFFF_FFFF : cum_sum[31:0]);
    assign adv_diff = mem_rdata.cum - r_base;
    assign tri_prod = r_prod[MulW-1:0] + {r_prod[MulW-2:0], 1'b0};
    assign idx_in = IW'(i_s_axis_tdata[105:98]);
    assign idx_cl = (idx_in > IW'(SEGMENTS)) ? LastK : AW'(idx_in);

    always_comb begin
        if (!r_neg) begin
            div_val = (r_dq > MaxPos) ? 32'sh7FFF_FFFF : signed'(r_dq[31:0]);
        end else begin
            div_val = (r_dq > MaxPos + 1'b1) ? 32'sh8000_0000 : signed'(32'(-r_dq));
        end
    end

    always_comb begin
        unique case (r_coord)
            2'd0:    pt = r_ctrl_x[r_term];
            2'd1:    pt = r_ctrl_y[r_term];
            default: pt = r_ctrl_z[r_term];
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_s_axis_tuser))
                        CMD_LOAD:  n_state = ST_DONE;
                        CMD_BUILD: n_state = ST_CMUL;
                        default:   n_state = ST_RD;
                    endcase
                end
            end
            ST_CMUL:  n_state = ST_CMULW;
            ST_CMULW: n_state = (r_op == 3'd5) ? ST_AMUL : ST_CMUL;
            ST_AMUL:  n_state = ST_AACC;
            ST_AACC:  n_state = (r_term == 2'd3) ? ST_RMUL : ST_AMUL;
            ST_RMUL:  n_state = ST_QMUL;
            ST_QMUL:  n_state = ST_QSUB;
            ST_QSUB:  n_state = ST_DIV;
            ST_DIV:   n_state = (r_rem >= RemDen) ? ST_DIV : ST_DIVW;
            ST_DIVW: begin
                if (r_coord != 2'd2) begin
                    n_state = ST_AMUL;
                end else begin
                    n_state = (r_k == '0) ? ST_BWR : ST_SMUL;
                end
            end
            ST_SMUL:  n_state = ST_SACC;
            ST_SACC: begin
                if (r_coord != 2'd2) begin
                    n_state = ST_SMUL;
                end else begin
                    n_state = (n_sq[65:64] != 2'd0) ? ST_BWR : ST_SQRT;
                end
            end
            ST_SQRT:  n_state = r_bit[0] ? ST_BWR : ST_SQRT;
            ST_BWR:   n_state = (r_k == LastK) ? ST_DONE : ST_CMUL;
            ST_RD:    n_state = ST_RDW;
            ST_RDW: begin
                if (!r_adv || r_k == LastK) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ADV;
                end
            end
            ST_ADV:   n_state = ST_ADVW;
            ST_ADVW: begin
                if (adv_diff > 32'(r_travel) || r_k == LastK) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ADV;
                end
            end
            ST_DONE:  n_state = (!r_out_valid || i_m_axis_tready) ? ST_IDLE : ST_DONE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        mem_we = (r_state == ST_BWR);
        mem_wdata = '{cum: cum_new, z: r_new[2], y: r_new[1], x: r_new[0]};
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_CMUL: begin
                unique case (r_op)
                    3'd0:    begin mul_a = a_ext; mul_b = a_ext; end
                    3'd1:    begin mul_a = b_ext; mul_b = b_ext; end
                    3'd2:    begin mul_a = r_aa;  mul_b = a_ext; end
                    3'd3:    begin mul_a = r_aa;  mul_b = b_ext; end
                    3'd4:    begin mul_a = a_ext; mul_b = r_bb;  end
                    default: begin mul_a = r_bb;  mul_b = b_ext; end
                endcase
            end
            ST_AMUL: begin
                mul_a = r_coef[r_term];
                mul_b = MulW'(pt);
            end
            ST_RMUL: begin
                mul_a = signed'(num_top);
                mul_b = signed'(MulW'(Recip));
            end
            ST_QMUL: begin
                mul_a = signed'(q_hat);
                mul_b = signed'(MulW'(Den));
            end
            ST_SMUL: begin
                mul_a = signed'(MulW'(adif));
                mul_b = signed'(MulW'(adif));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    balt_ram #(
        .WIDTH($bits(t_row)),
        .DEPTH(SEGMENTS + 1)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(r_k),
        .i_wdata(mem_wdata),
        .i_raddr(r_k),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_ctrl_x[i] <= '0;
                r_ctrl_y[i] <= '0;
                r_ctrl_z[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_m_axis_tvalid && i_m_axis_tready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_result <= '0;
                        r_result_idx <= '0;
                        r_result_pe <= 1'b0;
                        r_op <= '0;
                        r_prev_cum <= '0;
                        r_travel <= i_s_axis_tdata[136:106];
                        r_adv <= (t_cmd'(i_s_axis_tuser) == CMD_ADVANCE);
                        if (t_cmd'(i_s_axis_tuser) == CMD_LOAD) begin
                            r_ctrl_x[i_s_axis_tdata[1:0]] <= signed'(i_s_axis_tdata[33:2]);
                            r_ctrl_y[i_s_axis_tdata[1:0]] <= signed'(i_s_axis_tdata[65:34]);
                            r_ctrl_z[i_s_axis_tdata[1:0]] <= signed'(i_s_axis_tdata[97:66]);
                        end
                        r_k <= (t_cmd'(i_s_axis_tuser) == CMD_LOAD ||
                                t_cmd'(i_s_axis_tuser) == CMD_BUILD) ? '0 : idx_cl;
                    end
                end
                ST_CMULW: begin
                    unique case (r_op)
                        3'd0:    r_aa <= r_prod[MulW-1:0];
                        3'd1:    r_bb <= r_prod[MulW-1:0];
                        3'd2:    r_coef[0] <= r_prod[MulW-1:0];
                        3'd3:    r_coef[1] <= signed'(tri_prod);
                        3'd4:    r_coef[2] <= signed'(tri_prod);
                        default: r_coef[3] <= r_prod[MulW-1:0];
                    endcase
                    r_op <= r_op + 3'd1;
                    r_coord <= '0;
                    r_term <= '0;
                    r_acc <= '0;
                end
                ST_AACC: begin
                    r_acc <= n_acc;
                    r_term <= r_term + 2'd1;
                    r_neg <= n_acc[ProdW-1];
                    r_num <= unsigned'(acc_abs) + ProdW'(Half);
                end
                ST_QMUL: begin
                    r_dq <= ProdW'(q_hat);
                end
                ST_QSUB: begin
                    r_rem <= (DenW + 2)'(r_num - unsigned'(r_prod));
                end
                ST_DIV: begin
                    if (r_rem >= RemDen) begin
                        r_rem <= r_rem - RemDen;
                        r_dq <= r_dq + 1'b1;
                    end
                end
                ST_DIVW: begin
                    r_new[r_coord] <= div_val;
                    r_coord <= (r_coord == 2'd2) ? 2'd0 : r_coord + 2'd1;
                    r_term <= '0;
                    r_acc <= '0;
                    r_sq <= '0;
                    r_sat <= 1'b0;
                end
                ST_SACC: begin
                    r_sq <= n_sq;
                    r_coord <= r_coord + 2'd1;
                    r_sat <= (n_sq[65:64] != 2'd0);
                    r_v <= n_sq[63:0];
                    r_res <= '0;
                    r_bit <= 64'(1) << 62;
                end
                ST_SQRT: begin
                    if ({1'b0, r_v} >= sq_t) begin
                        r_v <= r_v - sq_t[63:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                ST_BWR: begin
                    for (int i = 0; i < 3; i++) begin
                        r_prev[i] <= r_new[i];
                    end
                    r_prev_cum <= cum_new;
                    r_op <= '0;
                    if (r_k == LastK) begin
                        r_result.cum <= cum_new;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_RDW: begin
                    r_base <= mem_rdata.cum;
                    r_row <= mem_rdata;
                    if (!r_adv) begin
                        r_result <= mem_rdata;
                        r_result_idx <= 8'(r_k);
                    end else if (r_k == LastK) begin
                        r_result <= '{cum: 32'(r_travel), z: mem_rdata.z,
                                      y: mem_rdata.y, x: mem_rdata.x};
                        r_result_idx <= 8'(r_k);
                        r_result_pe <= 1'b1;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_ADVW: begin
                    if (adv_diff > 32'(r_travel)) begin
                        r_result <= '{cum: 32'(r_travel) - (r_row.cum - r_base),
                                      z: r_row.z, y: r_row.y, x: r_row.x};
                        r_result_idx <= 8'(r_k - 1'b1);
                    end else if (r_k == LastK) begin
                        r_result <= '{cum: 32'(r_travel) - adv_diff,
                                      z: mem_rdata.z, y: mem_rdata.y, x: mem_rdata.x};
                        r_result_idx <= 8'(r_k);
                        r_result_pe <= 1'b1;
                    end else begin
                        r_row <= mem_rdata;
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out <= r_result;
                        r_out_idx <= r_result_idx;
                        r_out_pe <= r_result_pe;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata = {r_out_idx, r_out};
    assign o_m_axis_tuser = r_out_pe;

    a_pe_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> (o_m_axis_tdata[135:128] == 8'(SEGMENTS)))
        else $error("past-end result without last index");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_state != ST_DONE) |-> (r_k <= LastK))
        else $error("table index out of range");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result loaded outside the done state");

    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |-> $onehot(r_bit))
        else $error("square root step bit lost");

endmodule
